### hdl/alpha_blend_over_assert.svh
// Assertion macros for the alpha blend block; empty when SYNTH is defined.
`ifndef ALPHA_BLEND_OVER_ASSERT_SVH
`define ALPHA_BLEND_OVER_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication, sampled on clk, off during reset.
`define ABO_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("alpha_blend_over: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define ABO_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("alpha_blend_over: next-cycle check failed");

`else

`define ABO_ASSERT_IMPL(lbl, ante, cons)
`define ABO_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### hdl/abo_pkg.sv
// Constants, register codes and the divide-by-255 helper for the alpha blend block.
package abo_pkg;

    localparam int unsigned NUM_CH     = 3;
    localparam int unsigned ALPHA_LSB  = 24;
    localparam int unsigned NUM_STAGES = 9;
    localparam logic [7:0]  ALPHA_MAX  = 8'hFF;

    typedef enum logic [1:0] {
        REG_RED   = 2'd0,
        REG_GREEN = 2'd1,
        REG_BLUE  = 2'd2
    } reg_idx_t;

    // floor(y/255) for y < 2^24: y * (2^24 + 2^16 + 2^8 + 2) >> 32, exact over that range.
    function automatic logic [16:0] div255(input logic [23:0] y);
        logic [48:0] ext;
        logic [48:0] acc;
        ext = {25'd0, y};
        acc = (ext << 24) + (ext << 16) + (ext << 8) + (ext << 1);
        return acc[48:32];
    endfunction

endpackage

### hdl/alpha_blend_over.sv
// Porter-Duff "over" blender for non-premultiplied 32-bit pixel words.
// Composites source_pixel over backdrop_pixel. Alpha is bits 31:24 of both words; red,
// green and blue are 8-bit channels at bit offsets set by three APB registers (byte
// addresses 0x0 red, 0x4 green, 0x8 blue; reset 16, 8, 0; 5 bits each). A source alpha
// of zero passes the backdrop word through untouched. Otherwise out alpha is
// sa + da*(255-sa)/255 and each channel is (cs*sa + cd*da*(255-sa)/255) / out_alpha,
// truncating, saturated at 255, then ORed back at its offset (bits past 31 drop off).
// Throughput is one item per clock while blend_ready does not stall the output.
// The 9-stage pipeline is: channel extract, 8x8 multiplies, 8x16 multiply plus alpha,
// reciprocal divide by 255, numerator sum, three restoring-divide stages (three quotient
// bits each, one divider per channel), then saturate/pack into the output register.
// Each stage has its own valid bit and a ready chain, so bubbles collapse and a stalled
// output still lets new items fill empty stages. Only write the position registers
// while the pipeline is empty; items in flight use the live register values.
`include "alpha_blend_over_assert.svh"

module alpha_blend_over (
    input  logic        clk,
    input  logic        rst_n,
    // pixel pair in
    input  logic        pixel_valid,
    output logic        pixel_ready,
    input  logic [31:0] source_pixel,
    input  logic [31:0] backdrop_pixel,
    // blended item out
    output logic        blend_valid,
    input  logic        blend_ready,
    output logic [31:0] blended_pixel,
    // APB config
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned NS = abo_pkg::NUM_STAGES;
    localparam int unsigned NC = abo_pkg::NUM_CH;

    // ---------------- config registers ----------------
    logic [4:0] red_pos_reg;
    logic [4:0] green_pos_reg;
    logic [4:0] blue_pos_reg;
    logic [4:0] pos [NC];
    logic       cfg_wr;
    abo_pkg::reg_idx_t cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = abo_pkg::reg_idx_t'(paddr[3:2]);

    assign pos[0] = red_pos_reg;
    assign pos[1] = green_pos_reg;
    assign pos[2] = blue_pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_pos_reg   <= 5'd16;
            green_pos_reg <= 5'd8;
            blue_pos_reg  <= 5'd0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                abo_pkg::REG_RED:   red_pos_reg   <= pwdata[4:0];
                abo_pkg::REG_GREEN: green_pos_reg <= pwdata[4:0];
                abo_pkg::REG_BLUE:  blue_pos_reg  <= pwdata[4:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            abo_pkg::REG_RED:   prdata = {27'd0, red_pos_reg};
            abo_pkg::REG_GREEN: prdata = {27'd0, green_pos_reg};
            abo_pkg::REG_BLUE:  prdata = {27'd0, blue_pos_reg};
            default:            prdata = 32'd0;
        endcase
    end

    // ---------------- pipeline control ----------------
    logic [NS-1:0] v_reg;
    logic [NS-1:0] rdy;
    logic [NS-1:0] vin;
    logic [NS-1:0] ld;

    assign vin = {v_reg[NS-2:0], pixel_valid};
    assign ld  = rdy & vin;

    // a stage can take a new item when empty or when its item moves on
    always_comb
    begin
        rdy[NS-1] = !v_reg[NS-1] || blend_ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NS; k++)
            begin
                if (rdy[k])
                begin
                    v_reg[k] <= vin[k];
                end
            end
        end
    end

    assign pixel_ready = rdy[0];
    assign blend_valid = v_reg[NS-1];

    // ---------------- datapath registers ----------------
    // carried along the divide chain
    logic [31:0] bd_reg   [0:7];
    logic        pass_reg [0:7];
    logic [7:0]  sa_reg   [0:1];
    logic [7:0]  oa_reg   [2:7];

    logic [7:0]  da_reg;
    logic [7:0]  inv_reg;
    logic [15:0] t_reg;
    logic [7:0]  cs_reg  [NC];
    logic [7:0]  cd_reg  [0:1][NC];
    logic [15:0] ps_reg  [1:3][NC];
    logic [23:0] pd_reg  [NC];
    logic [15:0] pq_reg  [NC];
    logic [16:0] rem_reg [4:7][NC];
    logic [8:0]  q_reg   [5:7][NC];
    logic [31:0] blended_pixel_reg;

    // next values
    logic [7:0]  sa_next;
    logic [7:0]  da_next;
    logic [7:0]  cs_next [NC];
    logic [7:0]  cd_next [NC];
    logic [15:0] t_next;
    logic [15:0] ps_next [NC];
    logic [7:0]  oa_next;
    logic [16:0] oa_q;
    logic [8:0]  oa_sum;
    logic [23:0] pd_next [NC];
    logic [15:0] pq_next [NC];
    logic [16:0] pq_q    [NC];
    logic [16:0] rem_next [5:7][NC];
    logic [8:0]  q_next   [5:7][NC];
    logic [31:0] blended_pixel_next;

    // stage 0: pick alphas and channels out of both words
    always_comb
    begin
        sa_next = source_pixel[abo_pkg::ALPHA_LSB +: 8];
        da_next = backdrop_pixel[abo_pkg::ALPHA_LSB +: 8];
        for (int c = 0; c < NC; c++)
        begin
            cs_next[c] = 8'(source_pixel >> pos[c]);
            cd_next[c] = 8'(backdrop_pixel >> pos[c]);
        end
    end

    // stage 1: t = da*(255-sa), ps = cs*sa
    always_comb
    begin
        t_next = {8'd0, da_reg} * {8'd0, inv_reg};
        for (int c = 0; c < NC; c++)
        begin
            ps_next[c] = {8'd0, cs_reg[c]} * {8'd0, sa_reg[0]};
        end
    end

    // stage 2: out alpha, pd = cd*t
    always_comb
    begin
        oa_q    = abo_pkg::div255({8'd0, t_reg});
        oa_sum  = {1'b0, sa_reg[1]} + {1'b0, oa_q[7:0]};
        oa_next = oa_sum[7:0];
        for (int c = 0; c < NC; c++)
        begin
            pd_next[c] = {16'd0, cd_reg[1][c]} * {8'd0, t_reg};
        end
    end

    // stage 3: pd / 255
    always_comb
    begin
        for (int c = 0; c < NC; c++)
        begin
            pq_q[c]    = abo_pkg::div255(pd_reg[c]);
            pq_next[c] = pq_q[c][15:0];
        end
    end

    // stages 5..7: restoring divide, 3 quotient bits per stage.
    // Quotient stays below 512 for any nonzero source alpha.
    for (genvar gj = 0; gj < 3; gj++)
    begin : g_div
        // partial quotient comes from the previous divide stage
        localparam int unsigned QSRC = (gj == 0) ? 5 : 4 + gj;
        for (genvar gc = 0; gc < NC; gc++)
        begin : g_ch
            always_comb
            begin
                logic [16:0] r;
                logic [8:0]  q;
                logic [16:0] dsh;
                r = rem_reg[4+gj][gc];
                if (gj == 0)
                begin
                    q = 9'd0;
                end
                else
                begin
                    q = q_reg[QSRC][gc];
                end
                for (int s = 0; s < 3; s++)
                begin
                    dsh = {9'd0, oa_reg[4+gj]} << (8 - 3*gj - s);
                    if (r >= dsh)
                    begin
                        r = r - dsh;
                        q[8 - 3*gj - s] = 1'b1;
                    end
                end
                rem_next[5+gj][gc] = r;
                q_next[5+gj][gc]   = q;
            end
        end
    end

    // stage 8: saturate and pack
    always_comb
    begin
        logic [7:0]  ch;
        logic [31:0] packed_word;
        packed_word = {oa_reg[7], 24'd0};
        for (int c = 0; c < NC; c++)
        begin
            ch = q_reg[7][c][8] ? abo_pkg::ALPHA_MAX : q_reg[7][c][7:0];
            packed_word = packed_word | ({24'd0, ch} << pos[c]);
        end
        blended_pixel_next = pass_reg[7] ? bd_reg[7] : packed_word;
    end

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            sa_reg[0]   <= sa_next;
            da_reg      <= da_next;
            inv_reg     <= abo_pkg::ALPHA_MAX - sa_next;
            pass_reg[0] <= (sa_next == 8'd0);
            bd_reg[0]   <= backdrop_pixel;
            cs_reg      <= cs_next;
            cd_reg[0]   <= cd_next;
        end
        for (int k = 1; k < 8; k++)
        begin
            if (ld[k])
            begin
                bd_reg[k]   <= bd_reg[k-1];
                pass_reg[k] <= pass_reg[k-1];
            end
        end
        if (ld[1])
        begin
            sa_reg[1] <= sa_reg[0];
            t_reg     <= t_next;
            ps_reg[1] <= ps_next;
            cd_reg[1] <= cd_reg[0];
        end
        if (ld[2])
        begin
            oa_reg[2] <= oa_next;
            ps_reg[2] <= ps_reg[1];
            pd_reg    <= pd_next;
        end
        if (ld[3])
        begin
            oa_reg[3] <= oa_reg[2];
            ps_reg[3] <= ps_reg[2];
            pq_reg    <= pq_next;
        end
        if (ld[4])
        begin
            oa_reg[4] <= oa_reg[3];
            for (int c = 0; c < NC; c++)
            begin
                rem_reg[4][c] <= {1'b0, ps_reg[3][c]} + {1'b0, pq_reg[c]};
            end
        end
        for (int k = 5; k < 8; k++)
        begin
            if (ld[k])
            begin
                oa_reg[k]  <= oa_reg[k-1];
                rem_reg[k] <= rem_next[k];
                q_reg[k]   <= q_next[k];
            end
        end
        if (ld[8])
        begin
            blended_pixel_reg <= blended_pixel_next;
        end
    end

    assign blended_pixel = blended_pixel_reg;

    // ---------------- checks ----------------
    // open output means the whole ready chain is open
    `ABO_ASSERT_IMPL(a_ready_chain, blend_ready, pixel_ready)
    // an accepted item lands in the first stage
    `ABO_ASSERT_NEXT(a_enter, pixel_valid && pixel_ready, v_reg[0])
    // divider finished: channel 0 remainder below the divisor on blended items
    `ABO_ASSERT_IMPL(a_div_rem, v_reg[7] && !pass_reg[7], (rem_reg[7][0] < {9'd0, oa_reg[7]}))

endmodule
